### src/sftd_pkg.sv
package sftd_pkg;

   localparam int unsigned CHANNELS = 16;
   localparam int unsigned SENSORS = 4;
   localparam int unsigned CH_W = 4;
   localparam int unsigned SENS_W = 2;

   localparam logic [16:0] SYNC_NONE = 17'd0;
   localparam logic [15:0] DELTA_ABSENT = 16'h7FFF;
   localparam logic [3:0] WARMUP = 4'd12;
   localparam logic [31:0] NEAR_GAP = 32'd100;
   localparam logic [31:0] PERIOD_LO = 32'd830770;
   localparam logic [31:0] PERIOD_HI = 32'd1015384;
   localparam logic [31:0] STAMP_SPAN = 32'h0100_0000;
   localparam logic [63:0] STAMP_FIELD = 64'h0000_0000_00FF_FFFF;
   localparam logic [15:0] MASK_RESET = 16'hFFFF;

   localparam logic EV_SYNC = 1'b0;
   localparam logic EV_SWEEP = 1'b1;

   function automatic logic [19:0] period_of(input logic [CH_W-1:0] ch);
      logic [19:0] p;
      case (ch)
         4'd0: p = 20'd959001;
         4'd1: p = 20'd957001;
         4'd2: p = 20'd952999;
         4'd3: p = 20'd948999;
         4'd4: p = 20'd947000;
         4'd5: p = 20'd943000;
         4'd6: p = 20'd940999;
         4'd7: p = 20'd939000;
         4'd8: p = 20'd937000;
         4'd9: p = 20'd928999;
         4'd10: p = 20'd919000;
         4'd11: p = 20'd910999;
         4'd12: p = 20'd907000;
         4'd13: p = 20'd901001;
         4'd14: p = 20'd893000;
         4'd15: p = 20'd887000;
         default: p = 20'd959001;
      endcase
      return p;
   endfunction

   // one accepted frame, handed from front to back
   typedef struct packed {
      logic [CH_W-1:0] channel;
      logic ootx;
      logic [63:0] ref_time;
      logic [31:0] pulse_time;
      logic [SENSORS-1:0] present;
      logic [SENSORS-1:0][15:0] delta;
   } frame_type;

   typedef struct packed {
      logic kind;
      logic [CH_W-1:0] channel;
      logic [SENS_W-1:0] sensor;
      logic [31:0] time_code;
      logic ootx;
      logic last;
   } event_type;

endpackage

### src/sftd_front.sv
module sftd_front (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input logic [16:0] req_sync_count,
   input logic req_ootx_bit,
   input logic [3:0] req_channel,
   input logic [23:0] req_ref_stamp,
   input logic [15:0] req_sensor_delta_0,
   input logic [15:0] req_sensor_delta_1,
   input logic [15:0] req_sensor_delta_2,
   input logic [15:0] req_sensor_delta_3,
   input logic csr_write,
   input logic [15:0] csr_wdata,
   output logic frm_valid,
   input logic frm_ready,
   output sftd_pkg::frame_type frm_data
);

   logic [23:0] prev_stamp_ff, prev_stamp_in;
   logic [38:0] wrap_ff, wrap_in;
   logic [15:0] mask_ff, mask_in;
   logic frm_valid_ff, frm_valid_in;
   sftd_pkg::frame_type frm_ff, frm_in;

   logic take;
   logic keep;
   logic [63:0] ref_now;
   logic [63:0] s24;
   logic [15:0] deltas [4];

   assign req_full = frm_valid_ff && !frm_ready;
   assign take = req_push && !req_full;
   assign deltas[0] = req_sensor_delta_0;
   assign deltas[1] = req_sensor_delta_1;
   assign deltas[2] = req_sensor_delta_2;
   assign deltas[3] = req_sensor_delta_3;

   always_comb begin
      wrap_in = wrap_ff;
      if (prev_stamp_ff > req_ref_stamp) begin
         wrap_in = wrap_ff + 39'd1;
      end
      ref_now = {wrap_in, req_ref_stamp, 1'b1};
      s24 = {44'd0, req_sync_count, 3'b100};
      keep = (req_sync_count != sftd_pkg::SYNC_NONE) && mask_ff[req_channel];
      frm_in.channel = req_channel;
      frm_in.ootx = req_ootx_bit;
      frm_in.ref_time = ref_now;
      if (s24 < ref_now) begin
         frm_in.pulse_time = 32'(ref_now - s24);
      end else begin
         frm_in.pulse_time = 32'(ref_now + sftd_pkg::STAMP_FIELD - s24);
      end
      for (int i = 0; i < sftd_pkg::SENSORS; i++) begin
         frm_in.delta[i] = deltas[i];
         frm_in.present[i] = deltas[i] != sftd_pkg::DELTA_ABSENT;
      end
   end

   always_comb begin
      prev_stamp_in = take ? req_ref_stamp : prev_stamp_ff;
      mask_in = csr_write ? csr_wdata : mask_ff;
      frm_valid_in = frm_valid_ff;
      if (frm_valid_ff && frm_ready) begin
         frm_valid_in = 1'b0;
      end
      if (take) begin
         frm_valid_in = keep;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_stamp_ff <= '0;
         wrap_ff <= '0;
         mask_ff <= sftd_pkg::MASK_RESET;
         frm_valid_ff <= 1'b0;
      end else begin
         prev_stamp_ff <= prev_stamp_in;
         if (take) begin
            wrap_ff <= wrap_in;
         end
         mask_ff <= mask_in;
         frm_valid_ff <= frm_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && keep) begin
         frm_ff <= frm_in;
      end
   end

   assign frm_valid = frm_valid_ff;
   assign frm_data = frm_ff;

`ifndef SYNTH
   a_full_only_loaded: assert property (@(posedge clock) disable iff (reset)
      req_full |-> frm_valid_ff) else $error("full without a held frame");
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      frm_valid_ff && !frm_ready |=> frm_valid_ff && $stable(frm_ff))
      else $error("stalled frame changed");
   a_wrap_on_drop: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(wrap_ff)) else $error("wrap moved with no transfer");
`endif

endmodule

### src/sftd_back.sv
module sftd_back (
   input logic clock,
   input logic reset,
   input logic frm_valid,
   output logic frm_ready,
   input sftd_pkg::frame_type frm_data,
   output logic rsp_empty,
   input logic rsp_pop,
   output sftd_pkg::event_type rsp_data
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_TRACK = 5'b00010,
      ST_DIV = 5'b00100,
      ST_EMIT = 5'b01000,
      ST_SWEEP = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   sftd_pkg::frame_type cur_ff, cur_in;

   logic [sftd_pkg::CHANNELS-1:0][31:0] prior_ff, prior_in;
   logic [sftd_pkg::CHANNELS-1:0][3:0] tally_ff, tally_in;
   logic [sftd_pkg::CHANNELS-1:0] known_ff, known_in;
   logic [sftd_pkg::CHANNELS-1:0][31:0] offs_ff, offs_in;
   logic [sftd_pkg::CHANNELS-1:0][31:0] lastq_ff, lastq_in;

   // restoring divider: 64-bit dividend, 20-bit divisor, one bit a cycle
   logic [63:0] quo_ff, quo_in;
   logic [20:0] rem_ff, rem_in;
   logic [6:0] cnt_ff, cnt_in;
   logic div_mod_ff, div_mod_in;
   logic [19:0] per;
   logic [20:0] trial;

   logic [2:0] sidx_ff, sidx_in;
   logic sync_ff, sync_in;
   logic out_valid_ff, out_valid_in;
   sftd_pkg::event_type out_ff, out_in;

   logic [sftd_pkg::CH_W-1:0] ch;
   logic [32:0] p_ext;
   logic [31:0] d;
   logic [31:0] q32;
   logic slot_free;
   logic [sftd_pkg::SENSORS-1:0] later;

   assign ch = cur_ff.channel;
   assign per = sftd_pkg::period_of(ch);
   assign trial = {rem_ff[19:0], quo_ff[63]};
   assign slot_free = !out_valid_ff || rsp_pop;
   assign frm_ready = state_ff == ST_IDLE;
   assign q32 = quo_ff[31:0];

   always_comb begin
      later = '0;
      for (int i = 0; i < sftd_pkg::SENSORS; i++) begin
         if (3'(i) > sidx_ff) begin
            later[i] = cur_ff.present[i];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      prior_in = prior_ff;
      tally_in = tally_ff;
      known_in = known_ff;
      offs_in = offs_ff;
      lastq_in = lastq_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      div_mod_in = div_mod_ff;
      sidx_in = sidx_ff;
      sync_in = sync_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in = out_ff;
      p_ext = {1'b0, prior_ff[ch]};
      d = '0;
      case (state_ff)
         ST_IDLE: begin
            if (frm_valid) begin
               cur_in = frm_data;
               state_in = ST_TRACK;
            end
         end
         ST_TRACK: begin
            prior_in[ch] = cur_ff.pulse_time;
            if (tally_ff[ch] < sftd_pkg::WARMUP) begin
               tally_in[ch] = tally_ff[ch] + 4'd1;
            end
            if (tally_in[ch] == sftd_pkg::WARMUP) begin
               if (p_ext[31:0] > cur_ff.pulse_time) begin
                  p_ext = p_ext - {1'b0, sftd_pkg::STAMP_SPAN};
               end
               if (!p_ext[32] && p_ext[31:0] <= cur_ff.pulse_time) begin
                  d = cur_ff.pulse_time - p_ext[31:0];
                  if ($signed(d) < $signed(sftd_pkg::NEAR_GAP)) begin
                     offs_in[ch] = p_ext[31:0] + 32'($signed(d) / 2);
                     known_in[ch] = 1'b1;
                  end else if (d >= sftd_pkg::PERIOD_LO && d <= sftd_pkg::PERIOD_HI) begin
                     offs_in[ch] = cur_ff.pulse_time;
                     known_in[ch] = 1'b1;
                  end
               end
            end
            // first pass: offset mod period
            quo_in = {offs_in[ch], 32'd0};
            rem_in = '0;
            cnt_in = 7'd32;
            div_mod_in = 1'b1;
            sync_in = 1'b0;
            state_in = known_in[ch] ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            if (cnt_ff != 7'd0) begin
               if (trial >= {1'b0, per}) begin
                  rem_in = trial - {1'b0, per};
                  quo_in = {quo_ff[62:0], 1'b1};
               end else begin
                  rem_in = trial;
                  quo_in = {quo_ff[62:0], 1'b0};
               end
               cnt_in = cnt_ff - 7'd1;
            end else if (div_mod_ff) begin
               quo_in = cur_ff.ref_time - {44'd0, rem_ff[19:0]};
               rem_in = '0;
               cnt_in = 7'd64;
               div_mod_in = 1'b0;
            end else begin
               if (q32 != 32'd0 && lastq_ff[ch] < q32) begin
                  lastq_in[ch] = q32;
                  sync_in = 1'b1;
               end
               sidx_in = '0;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sync_ff) begin
               if (slot_free) begin
                  out_valid_in = 1'b1;
                  out_in.kind = sftd_pkg::EV_SYNC;
                  out_in.channel = ch;
                  out_in.sensor = '0;
                  out_in.time_code = cur_ff.pulse_time;
                  out_in.ootx = cur_ff.ootx;
                  out_in.last = cur_ff.present == '0;
                  sync_in = 1'b0;
                  state_in = ST_SWEEP;
               end
            end else begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sidx_ff >= 3'(sftd_pkg::SENSORS)) begin
               state_in = ST_IDLE;
            end else if (!cur_ff.present[sidx_ff[sftd_pkg::SENS_W-1:0]]) begin
               sidx_in = sidx_ff + 3'd1;
            end else if (slot_free) begin
               out_valid_in = 1'b1;
               out_in.kind = sftd_pkg::EV_SWEEP;
               out_in.channel = ch;
               out_in.sensor = sidx_ff[sftd_pkg::SENS_W-1:0];
               out_in.time_code = cur_ff.ref_time[31:0]
                  + {{15{cur_ff.delta[sidx_ff[sftd_pkg::SENS_W-1:0]][15]}},
                     cur_ff.delta[sidx_ff[sftd_pkg::SENS_W-1:0]], 1'b1};
               out_in.ootx = 1'b0;
               out_in.last = later == '0;
               sidx_in = sidx_ff + 3'd1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         prior_ff <= '0;
         tally_ff <= '0;
         known_ff <= '0;
         lastq_ff <= '0;
         out_valid_ff <= 1'b0;
         sync_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         prior_ff <= prior_in;
         tally_ff <= tally_in;
         known_ff <= known_in;
         lastq_ff <= lastq_in;
         out_valid_ff <= out_valid_in;
         sync_ff <= sync_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      offs_ff <= offs_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      div_mod_ff <= div_mod_in;
      sidx_ff <= sidx_in;
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;

`ifndef SYNTH
   a_div_runs_down: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV && cnt_ff != 7'd0 |=> state_ff == ST_DIV)
      else $error("divider left early");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_pop |=> out_valid_ff && $stable(out_ff))
      else $error("waiting event overwritten");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      frm_ready |-> !sync_ff) else $error("sync pending while idle");
`endif

endmodule

### src/sweep_frame_timestamp_decoder.sv
// Sweep frame timestamp decoder.
// Input channel: queue-like; a frame transfers when req_push is high and
// req_full is low. Frames with a zero sync count or a disabled channel are
// dropped after their stamp is taken into the wrap count.
// Result channel: rsp_empty low shows the oldest event; rsp_pop transfers it.
// A frame yields up to five events; rsp_last marks the final one.
// csr_write loads csr_wdata into the channel enable mask at once.
// Flow: a frame waits in the front register until the back end is idle; the
// back end then does phase tracking and runs the bit-serial divider in steps
// (32 steps for offset mod period, one to set up, 64 for the period index,
// one to compare), and only then shows its first event. It then emits the
// sync slot and each of the four sensor slots in turn. The back end takes a
// new frame only once it is idle again after its last event.
// Dropped frames never reach the back end; frames with unknown phase
// leave it after phase tracking, with no division.
// Reset clears the wrap count, per-channel trackers and both queues and sets
// the enable mask to all ones. When the receiver stalls, the back end holds
// its event; the front register fills and req_full rises.
module sweep_frame_timestamp_decoder (
   input logic clock,
   input logic reset,
   input logic req_push,
   output logic req_full,
   input logic [16:0] req_sync_count,
   input logic req_ootx_bit,
   input logic [3:0] req_channel,
   input logic [23:0] req_ref_stamp,
   input logic [15:0] req_sensor_delta_0,
   input logic [15:0] req_sensor_delta_1,
   input logic [15:0] req_sensor_delta_2,
   input logic [15:0] req_sensor_delta_3,
   output logic rsp_empty,
   input logic rsp_pop,
   output logic rsp_event_kind,
   output logic [3:0] rsp_event_channel,
   output logic [1:0] rsp_sensor_index,
   output logic [31:0] rsp_event_time,
   output logic rsp_event_ootx,
   output logic rsp_last,
   input logic csr_write,
   input logic [15:0] csr_wdata
);

   logic frm_valid;
   logic frm_ready;
   sftd_pkg::frame_type frm_data;
   sftd_pkg::event_type ev;

   sftd_front u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_sync_count(req_sync_count), .req_ootx_bit(req_ootx_bit),
      .req_channel(req_channel), .req_ref_stamp(req_ref_stamp),
      .req_sensor_delta_0(req_sensor_delta_0),
      .req_sensor_delta_1(req_sensor_delta_1),
      .req_sensor_delta_2(req_sensor_delta_2),
      .req_sensor_delta_3(req_sensor_delta_3),
      .csr_write(csr_write), .csr_wdata(csr_wdata),
      .frm_valid(frm_valid), .frm_ready(frm_ready), .frm_data(frm_data)
   );

   sftd_back u_back (
      .clock(clock), .reset(reset),
      .frm_valid(frm_valid), .frm_ready(frm_ready), .frm_data(frm_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(ev)
   );

   assign rsp_event_kind = ev.kind;
   assign rsp_event_channel = ev.channel;
   assign rsp_sensor_index = ev.sensor;
   assign rsp_event_time = ev.time_code;
   assign rsp_event_ootx = ev.ootx;
   assign rsp_last = ev.last;

endmodule

### test/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 300;
   localparam int TARGET_FRAMES = 360;
   localparam int MAX_REPORTS = 10;

   typedef struct packed {
      logic [16:0] sync_count;
      logic ootx;
      logic [3:0] channel;
      logic [23:0] stamp;
      logic [3:0][15:0] delta;
   } frame_item_type;

   logic clock = 1'b0;
   logic reset;
   logic req_push;
   logic req_full;
   logic [16:0] req_sync_count;
   logic req_ootx_bit;
   logic [3:0] req_channel;
   logic [23:0] req_ref_stamp;
   logic [15:0] req_sensor_delta_0, req_sensor_delta_1;
   logic [15:0] req_sensor_delta_2, req_sensor_delta_3;
   logic rsp_empty;
   logic rsp_pop;
   logic rsp_event_kind;
   logic [3:0] rsp_event_channel;
   logic [1:0] rsp_sensor_index;
   logic [31:0] rsp_event_time;
   logic rsp_event_ootx;
   logic rsp_last;
   logic csr_write;
   logic [15:0] csr_wdata;

   sweep_frame_timestamp_decoder dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full),
      .req_sync_count(req_sync_count), .req_ootx_bit(req_ootx_bit),
      .req_channel(req_channel), .req_ref_stamp(req_ref_stamp),
      .req_sensor_delta_0(req_sensor_delta_0),
      .req_sensor_delta_1(req_sensor_delta_1),
      .req_sensor_delta_2(req_sensor_delta_2),
      .req_sensor_delta_3(req_sensor_delta_3),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_event_kind(rsp_event_kind), .rsp_event_channel(rsp_event_channel),
      .rsp_sensor_index(rsp_sensor_index), .rsp_event_time(rsp_event_time),
      .rsp_event_ootx(rsp_event_ootx), .rsp_last(rsp_last),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder model state
   logic [15:0] enable_mask;
   logic [23:0] prev_stamp;
   logic [38:0] wraps;
   logic [31:0] prior_pulse [sftd_pkg::CHANNELS];
   logic [3:0] tally [sftd_pkg::CHANNELS];
   logic phase_ok [sftd_pkg::CHANNELS];
   logic [31:0] phase_at [sftd_pkg::CHANNELS];
   logic [31:0] last_index [sftd_pkg::CHANNELS];
   logic [19:0] period_ticks [sftd_pkg::CHANNELS] = '{
      20'd959001, 20'd957001, 20'd952999, 20'd948999, 20'd947000, 20'd943000,
      20'd940999, 20'd939000, 20'd937000, 20'd928999, 20'd919000, 20'd910999,
      20'd907000, 20'd901001, 20'd893000, 20'd887000};

   sftd_pkg::event_type pending_events[$];
   int mismatches = 0;
   int frames_sent = 0;
   int events_seen = 0;
   int sync_seen = 0;
   int sweep_seen = 0;
   int idle_cycles = 0;
   int pop_wait = 0;
   bit no_idle = 0;
   logic [23:0] cur_stamp = 24'd0;

   task automatic decode_frame(input frame_item_type f);
      logic [63:0] ref_t, s24, p, r, qq;
      logic [31:0] tc, q, ev_time;
      logic signed [31:0] d;
      sftd_pkg::event_type ev;
      sftd_pkg::event_type found[$];
      if (prev_stamp > f.stamp) wraps = wraps + 39'd1;
      prev_stamp = f.stamp;
      ref_t = {wraps, f.stamp, 1'b1};
      if (f.sync_count == sftd_pkg::SYNC_NONE || !enable_mask[f.channel]) return;
      s24 = 64'(f.sync_count) * 64'd8 + 64'd4;
      tc = (s24 < ref_t) ? 32'(ref_t - s24) : 32'(ref_t + 64'hFF_FFFF - s24);
      // phase tracker
      p = 64'(prior_pulse[f.channel]);
      prior_pulse[f.channel] = tc;
      if (tally[f.channel] < sftd_pkg::WARMUP) tally[f.channel]++;
      if (tally[f.channel] >= sftd_pkg::WARMUP
          && !(p > 64'(tc) && p < 64'(sftd_pkg::STAMP_SPAN))) begin
         if (p > 64'(tc)) p = p - 64'(sftd_pkg::STAMP_SPAN);
         if (p <= 64'(tc)) begin
            d = $signed(tc - p[31:0]);
            if (d < $signed(sftd_pkg::NEAR_GAP)) begin
               phase_at[f.channel] = p[31:0] + 32'(d / 2);
               phase_ok[f.channel] = 1'b1;
            end else if (d >= $signed(sftd_pkg::PERIOD_LO)
                         && d <= $signed(sftd_pkg::PERIOD_HI)) begin
               phase_at[f.channel] = tc;
               phase_ok[f.channel] = 1'b1;
            end
         end
      end
      if (phase_ok[f.channel]) begin
         r = 64'(phase_at[f.channel]) % 64'(period_ticks[f.channel]);
         qq = (ref_t - r) / 64'(period_ticks[f.channel]);
         q = qq[31:0];
         if (q != 0 && last_index[f.channel] < q) begin
            last_index[f.channel] = q;
            ev = '{kind: sftd_pkg::EV_SYNC, channel: f.channel, sensor: '0,
                   time_code: tc, ootx: f.ootx, last: 1'b0};
            found.push_back(ev);
         end
         for (int i = 0; i < sftd_pkg::SENSORS; i++) begin
            if (f.delta[i] != sftd_pkg::DELTA_ABSENT) begin
               ev_time = ref_t[31:0] + ({{16{f.delta[i][15]}}, f.delta[i]} << 1)
                         + 32'd1;
               ev = '{kind: sftd_pkg::EV_SWEEP, channel: f.channel,
                      sensor: sftd_pkg::SENS_W'(i), time_code: ev_time,
                      ootx: 1'b0, last: 1'b0};
               found.push_back(ev);
            end
         end
      end
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[k]) pending_events.push_back(found[k]);
   endtask

   function automatic int draw_gap();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   // Leaves req_push high on return; the next call or hold_sender settles it
   // in the same time step.
   task automatic send_frame(input frame_item_type f);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_sync_count <= f.sync_count;
      req_ootx_bit <= f.ootx;
      req_channel <= f.channel;
      req_ref_stamp <= f.stamp;
      req_sensor_delta_0 <= f.delta[0];
      req_sensor_delta_1 <= f.delta[1];
      req_sensor_delta_2 <= f.delta[2];
      req_sensor_delta_3 <= f.delta[3];
      do @(posedge clock); while (req_full);
      decode_frame(f);
      frames_sent++;
   endtask

   task automatic hold_sender();
      req_push <= 1'b0;
   endtask

   // wait out every expected event plus any dropped frame still in flight
   task automatic drain();
      hold_sender();
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_mask(input logic [15:0] value);
      csr_write <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      enable_mask = value;
      csr_write <= 1'b0;
   endtask

   function automatic logic [15:0] pick_delta();
      case ($urandom_range(0, 7))
         0, 1: return sftd_pkg::DELTA_ABSENT;
         2: return 16'h8000;
         3: return 16'h7FFE;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic frame_item_type noise_frame();
      frame_item_type f;
      f.sync_count = ($urandom_range(0, 5) == 0) ? sftd_pkg::SYNC_NONE
                                                 : 17'($urandom());
      f.ootx = 1'($urandom());
      f.channel = 4'($urandom());
      f.stamp = 24'($urandom());
      for (int i = 0; i < sftd_pkg::SENSORS; i++) f.delta[i] = pick_delta();
      return f;
   endfunction

   // a run of well-spaced pulses on one channel so the tracker locks
   task automatic sweep_burst(input logic [3:0] ch, input int count);
      frame_item_type f;
      logic [16:0] sc;
      sc = 17'($urandom_range(1, 131071));
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 7) != 0)
            cur_stamp = cur_stamp + 24'(period_ticks[ch] / 2)
                        + 24'($urandom_range(0, 20));
         f = noise_frame();
         f.sync_count = sc;
         f.channel = ch;
         f.stamp = cur_stamp;
         send_frame(f);
      end
   endtask

   task automatic test_directed();
      frame_item_type f;
      // lock channel 15 with repeated stamps, extreme deltas
      for (int n = 0; n < 14; n++) begin
         f = '{sync_count: 17'd1, ootx: 1'(n), channel: 4'd15, stamp: 24'd0,
               delta: {16'h8000, 16'h7FFE, 16'h0000, 16'h7FFF}};
         send_frame(f);
      end
      // pulse rollover: offset not below the reference
      f = '{sync_count: 17'h1FFFF, ootx: 1'b1, channel: 4'd15, stamp: 24'd100,
            delta: {16'hFFFF, 16'h0001, 16'h7FFF, 16'h8000}};
      send_frame(f);
      f.stamp = 24'hFF_FFFF;
      send_frame(f);
      f.stamp = 24'd0;             // wrap
      f.sync_count = 17'd3;
      send_frame(f);
      f.sync_count = sftd_pkg::SYNC_NONE;    // no sync
      send_frame(f);
      f.sync_count = 17'd5;
      f.channel = 4'd0;
      send_frame(f);
      drain();
      write_mask(16'h7FFF);        // disable channel 15
      f.channel = 4'd15;
      send_frame(f);
      f.stamp = 24'd10;
      send_frame(f);
      drain();
      write_mask(sftd_pkg::MASK_RESET);
   endtask

   task automatic test_bursts(input int frames_goal);
      while (frames_sent < frames_goal) begin
         if ($urandom_range(0, 3) == 0) send_frame(noise_frame());
         else sweep_burst(4'($urandom()), $urandom_range(4, 20));
      end
   endtask

   task automatic test_mask_settings();
      logic [15:0] masks[4] = '{16'h0000, 16'hAAAA, 16'($urandom()),
                                sftd_pkg::MASK_RESET};
      foreach (masks[m]) begin
         drain();
         write_mask(masks[m]);
         test_bursts(frames_sent + 25);
      end
   endtask

   task automatic test_no_idle();
      drain();
      no_idle = 1;
      test_bursts(frames_sent + 40);
      drain();
      no_idle = 0;
   endtask

   // receiver: random stall per transfer, compare against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
         pop_wait = 0;
      end else if (rsp_pop && !rsp_empty) begin
         sftd_pkg::event_type want;
         sftd_pkg::event_type got;
         got = '{kind: rsp_event_kind, channel: rsp_event_channel,
                 sensor: rsp_sensor_index, time_code: rsp_event_time,
                 ootx: rsp_event_ootx, last: rsp_last};
         events_seen++;
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected event kind=%0d ch=%0d sensor=%0d time=%h",
                        got.kind, got.channel, got.sensor, got.time_code);
         end else begin
            want = pending_events.pop_front();
            if (want.kind == sftd_pkg::EV_SYNC) sync_seen++; else sweep_seen++;
            if (got !== want) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"event mismatch: expected k=%0d ch=%0d s=%0d t=%h",
                            " o=%0d l=%0d, got k=%0d ch=%0d s=%0d t=%h o=%0d l=%0d"},
                           want.kind, want.channel, want.sensor, want.time_code,
                           want.ootx, want.last, got.kind, got.channel, got.sensor,
                           got.time_code, got.ootx, got.last);
            end
         end
         pop_wait = draw_gap();
         if (pop_wait > 0) rsp_pop <= 1'b0;
      end else if (!rsp_pop) begin
         if (pop_wait == 0) rsp_pop <= 1'b1;
         else pop_wait--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      reset <= 1'b1;
      req_push <= 1'b0;
      req_sync_count <= '0;
      req_ootx_bit <= 1'b0;
      req_channel <= '0;
      req_ref_stamp <= '0;
      req_sensor_delta_0 <= '0;
      req_sensor_delta_1 <= '0;
      req_sensor_delta_2 <= '0;
      req_sensor_delta_3 <= '0;
      csr_write <= 1'b0;
      csr_wdata <= '0;
      enable_mask = sftd_pkg::MASK_RESET;
      prev_stamp = '0;
      wraps = '0;
      for (int c = 0; c < sftd_pkg::CHANNELS; c++) begin
         prior_pulse[c] = '0;
         tally[c] = '0;
         phase_ok[c] = 1'b0;
         phase_at[c] = '0;
         last_index[c] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      write_mask(sftd_pkg::MASK_RESET);

      test_directed();
      test_mask_settings();
      test_no_idle();
      test_bursts(TARGET_FRAMES);
      drain();

      mismatches += pending_events.size();
      $display("Sent %0d frames; checked %0d events (%0d sync, %0d sweep).",
               frames_sent, events_seen, sync_seen, sweep_seen);
      $display("Covered channel lock-in, stamp wraps, pulse rollover and 5 mask settings.");
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
